### hw/rtl/rhe_pkg.sv
// rhe_pkg: shared types, constants and helpers for the RGB histogram engine.
// No dependencies; imported by the top level, rhe_ctrl and rhe_datapath.
package rhe_pkg;

   localparam int BIN_TOTAL  = 256;
   localparam int BIN_BITS   = $clog2(BIN_TOTAL);
   localparam int COUNT_BITS = 32;
   localparam int OUT_BITS   = 32;
   localparam int CHAN_TOTAL = 3;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_ADD   = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] red_code;
      logic [7:0] green_code;
      logic [7:0] blue_code;
      logic [7:0] bin_index;
   } req_type;

   typedef struct packed {
      logic [31:0] red_count;
      logic [31:0] green_count;
      logic [31:0] blue_count;
      logic [31:0] peak_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_UPDATE,
      ST_PEAK,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // request taken, RAM reads issued
      logic sweep;     // write zero at sweep address, advance
      logic update;    // read data back, count registered, written for add
      logic fold;      // fold new counts into peak
      logic load_rsp;  // fill output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic sweep_last;
      logic rsp_busy;
   } status_type;

   function automatic logic [OUT_BITS-1:0] to_out(input logic [COUNT_BITS-1:0] c);
      logic [OUT_BITS+COUNT_BITS-1:0] w;
      w = {{OUT_BITS{1'b0}}, c};
      return w[OUT_BITS-1:0];
   endfunction

endpackage

### hw/rtl/rgb_histogram_engine_unit.sv
// RGB histogram engine top level: three 256-bin channel histograms plus peak.
// Usage:
//   req_* channel: one transaction carries an operation and codes. Clear
//     zeroes every bin and the peak; add-pixel bumps the red, green and blue
//     bins of the codes (saturating) and folds the new counts of bins 1..255
//     into the peak; read (and code 3) returns the three counts of bin_index.
//   rsp_* channel: exactly one transaction per request, in order. Add returns
//     the new counts, read the stored counts, clear all zeros; all carry peak.
//   Sequence: add and read run through RAM read, update (with write back
//     for add only), peak fold and output load, in that order. One is in
//     flight at a time, as the read-modify-write of the bin RAMs sets the rate.
//   Clear sweeps all 256 rows of the bin RAMs, one row per cycle, and
//     holds req_stall high until its response is loaded.
//   Reset: synchronous, active high. After reset the same 256-row sweep
//     runs with req_stall high; no response is produced for it.
//   Back-pressure: the result sits in an output register while rsp_stall is
//     high; the next request is still accepted and processed, and waits at
//     its final step until the output register frees up.
// Depends on rhe_pkg, rhe_ctrl, rhe_datapath.
module rgb_histogram_engine_unit
   import rhe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   cmd_type    cmd;
   status_type status;

   // sequencer: owns the state machine and the request stall
   rhe_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_payload.operation),
      .req_stall     (req_stall),
      .status        (status),
      .cmd           (cmd)
   );

   // bins, peak and output register
   rhe_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

### hw/rtl/rhe_ram.sv
// rhe_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module rhe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/rhe_datapath.sv
// rhe_datapath: bin RAMs, saturating increment, peak register, sweep counter
// and output register. Depends on rhe_pkg and rhe_ram.
module rhe_datapath
   import rhe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_payload,
   input  cmd_type    cmd,
   output status_type status,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output rsp_type    rsp_payload
);

   req_type                 req_ff;
   logic [BIN_BITS-1:0]     sweep_addr_ff, sweep_addr_in;
   logic [COUNT_BITS-1:0]   peak_ff, peak_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic [BIN_BITS-1:0]     new_code [CHAN_TOTAL];
   logic [BIN_BITS-1:0]     held_code [CHAN_TOTAL];
   logic [BIN_BITS-1:0]     rd_addr [CHAN_TOTAL];
   logic [BIN_BITS-1:0]     wr_addr [CHAN_TOTAL];
   logic [COUNT_BITS-1:0]   wr_data [CHAN_TOTAL];
   logic [COUNT_BITS-1:0]   rd_data [CHAN_TOTAL];
   logic [COUNT_BITS-1:0]   cnt_ff [CHAN_TOTAL];
   logic [COUNT_BITS-1:0]   cnt_in [CHAN_TOTAL];
   logic                    wr_en;
   logic                    in_is_add;
   logic                    is_add;
   logic                    is_clear;

   assign new_code[0]  = req_payload.red_code;
   assign new_code[1]  = req_payload.green_code;
   assign new_code[2]  = req_payload.blue_code;
   assign held_code[0] = req_ff.red_code;
   assign held_code[1] = req_ff.green_code;
   assign held_code[2] = req_ff.blue_code;

   assign in_is_add = (req_payload.operation == OP_ADD);
   assign is_add    = (req_ff.operation == OP_ADD);
   assign is_clear  = (req_ff.operation == OP_CLEAR);
   assign wr_en     = cmd.sweep | (cmd.update & is_add);

   for (genvar c = 0; c < CHAN_TOTAL; c++) begin : g_chan
      assign rd_addr[c] = in_is_add ? new_code[c] : req_payload.bin_index;
      assign wr_addr[c] = cmd.sweep ? sweep_addr_ff : held_code[c];
      assign wr_data[c] = cmd.sweep ? '0 : cnt_in[c];
      // saturating increment for add, pass-through for read
      assign cnt_in[c]  = (is_add && (rd_data[c] != {COUNT_BITS{1'b1}}))
                          ? rd_data[c] + COUNT_BITS'(1) : rd_data[c];

      rhe_ram #(
         .WIDTH (COUNT_BITS),
         .DEPTH (BIN_TOTAL)
      ) u_bins (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (wr_addr[c]),
         .wr_data (wr_data[c]),
         .rd_en   (cmd.capture),
         .rd_addr (rd_addr[c]),
         .rd_data (rd_data[c])
      );

      always_ff @(posedge clock) begin
         if (cmd.update) begin
            cnt_ff[c] <= cnt_in[c];
         end
      end
   end

   // bin 0 never feeds the peak
   always_comb begin
      peak_in = peak_ff;
      for (int c = 0; c < CHAN_TOTAL; c++) begin
         if ((held_code[c] != '0) && (cnt_ff[c] > peak_in)) begin
            peak_in = cnt_ff[c];
         end
      end
   end

   assign sweep_addr_in = cmd.sweep ? sweep_addr_ff + BIN_BITS'(1) : sweep_addr_ff;

   always_comb begin
      rsp_in = rsp_ff;
      if (is_clear) begin
         rsp_in = '0;
      end else begin
         rsp_in.red_count   = to_out(cnt_ff[0]);
         rsp_in.green_count = to_out(cnt_ff[1]);
         rsp_in.blue_count  = to_out(cnt_ff[2]);
         rsp_in.peak_count  = to_out(peak_ff);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_addr_ff <= '0;
         peak_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         sweep_addr_ff <= sweep_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (cmd.capture && (req_payload.operation == OP_CLEAR)) begin
            peak_ff <= '0;
         end else if (cmd.fold && is_add) begin
            peak_ff <= peak_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign status.sweep_last = (sweep_addr_ff == BIN_BITS'(BIN_TOTAL - 1));
   assign status.rsp_busy   = rsp_valid_ff & rsp_stall;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_payload       = rsp_ff;

endmodule

### hw/rtl/rhe_ctrl.sv
// rhe_ctrl: sequencer for sweep, read-modify-write and response hand-off.
// Depends on rhe_pkg.
module rhe_ctrl
   import rhe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_operation,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      owed_ff, owed_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         owed_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         owed_ff  <= owed_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      owed_in   = owed_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = owed_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (req_operation == OP_CLEAR) begin
                  owed_in  = 1'b1;
                  state_in = ST_SWEEP;
               end else begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_PEAK;
         end
         ST_PEAK: begin
            cmd.fold = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!status.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               owed_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### test/tb_rgb_histogram_engine_unit.sv
// Self-checking testbench for rgb_histogram_engine_unit: a queue-fed driver and a
// response monitor, with a behavioral histogram model to predict each response.
// Depends on rhe_pkg and the RTL of the block only.
module tb_rgb_histogram_engine_unit;
   import rhe_pkg::*;

   // code 3 is undefined but decodes as a read (neither clear nor add)
   localparam logic [1:0] OP_READ_ALIAS = 2'd3;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int TAIL_CYCLES  = 20;
   localparam int PHASE_ITEMS  = 480;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   rgb_histogram_engine_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // transactions waiting to be driven, and responses still owed by the block
   req_type stim_q[$];
   rsp_type expected_q[$];

   int send_gap_pct;
   int rsp_hold_pct;
   int error_count;
   int cycle_count;

   // histogram model: one row of bins per channel, plus the running peak
   logic [COUNT_BITS-1:0] tally [CHAN_TOTAL][BIN_TOTAL];
   logic [COUNT_BITS-1:0] peak_tally;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Saturating increment of one bin; bins 1..255 feed the peak, bin 0 never does.
   function automatic logic [COUNT_BITS-1:0] bump_bin(input int chan,
                                                      input logic [7:0] code);
      if (tally[chan][code] != {COUNT_BITS{1'b1}})
         tally[chan][code] = tally[chan][code] + 1'b1;
      if (code != 8'd0 && tally[chan][code] > peak_tally)
         peak_tally = tally[chan][code];
      return tally[chan][code];
   endfunction

   // Advances the model by one request and returns the response it should produce.
   function automatic rsp_type histogram_step(input req_type t);
      rsp_type r;
      r = '0;
      case (t.operation)
         OP_CLEAR: begin
            for (int c = 0; c < CHAN_TOTAL; c++)
               for (int i = 0; i < BIN_TOTAL; i++)
                  tally[c][i] = '0;
            peak_tally = '0;
         end
         OP_ADD: begin
            r.red_count   = OUT_BITS'(bump_bin(0, t.red_code));
            r.green_count = OUT_BITS'(bump_bin(1, t.green_code));
            r.blue_count  = OUT_BITS'(bump_bin(2, t.blue_code));
         end
         default: begin
            r.red_count   = OUT_BITS'(tally[0][t.bin_index]);
            r.green_count = OUT_BITS'(tally[1][t.bin_index]);
            r.blue_count  = OUT_BITS'(tally[2][t.bin_index]);
         end
      endcase
      r.peak_count = OUT_BITS'(peak_tally);
      return r;
   endfunction

   // Driver: predicts each accepted transaction, then presents the next one or idles.
   // Valid and payload are held untouched while the block stalls.
   always @(posedge clock) begin : driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_q.push_back(histogram_step(req_payload));
         if (!req_valid || !req_stall) begin
            if (stim_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               req_valid   <= 1'b1;
               req_payload <= stim_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d (0x%08h), actual %0d (0x%08h)",
                  $time, name, want, want, got, got);
         error_count++;
      end
   endtask

   // Monitor: every accepted response is matched against the oldest prediction.
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected response, actual %h", $time, rsp_payload);
               error_count++;
            end else begin
               want = expected_q.pop_front();
               check_field("red_count",   want.red_count,   rsp_payload.red_count);
               check_field("green_count", want.green_count, rsp_payload.green_count);
               check_field("blue_count",  want.blue_count,  rsp_payload.blue_count);
               check_field("peak_count",  want.peak_count,  rsp_payload.peak_count);
            end
         end
         rsp_stall <= ($urandom_range(99) < rsp_hold_pct);
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("rgb_histogram_engine_unit test failed");
         $finish;
      end
   end

   task automatic push_req(input logic [1:0] op, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b, input logic [7:0] idx);
      req_type t;
      t.operation  = op;
      t.red_code   = r;
      t.green_code = g;
      t.blue_code  = b;
      t.bin_index  = idx;
      stim_q.push_back(t);
   endtask

   // Holds off new stimulus until every queued transaction is answered.
   task automatic wait_drained();
      do
         @(negedge clock);
      while (stim_q.size() != 0 || req_valid || expected_q.size() != 0);
   endtask

   // Half the picks land in a few hot bins so counts and the peak climb.
   function automatic logic [7:0] pick_code();
      return $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
   endfunction

   initial begin : stimulus
      int pick;
      logic [1:0] op;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_payload  = '0;
      rsp_stall    = 1'b0;
      send_gap_pct = 0;
      rsp_hold_pct = 0;
      error_count  = 0;
      cycle_count  = 0;
      for (int c = 0; c < CHAN_TOTAL; c++)
         for (int i = 0; i < BIN_TOTAL; i++)
            tally[c][i] = '0;
      peak_tally = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty reads after reset, bin 0 vs bin 255 and the peak,
      // the undefined opcode as a read, clear with junk fields, bit patterns.
      push_req(OP_READ,       8'hFF, 8'hFF, 8'hFF, 8'd0);
      push_req(OP_READ,       8'h00, 8'h00, 8'h00, 8'd255);
      push_req(OP_ADD,        8'd0,   8'd0,   8'd0,   8'hFF);  // bin 0 only: peak stays 0
      push_req(OP_ADD,        8'd255, 8'd255, 8'd255, 8'h00);
      push_req(OP_ADD,        8'd0,   8'd255, 8'd0,   8'h5A);
      push_req(OP_ADD,        8'd1,   8'd2,   8'd128, 8'd0);
      push_req(OP_ADD,        8'd0,   8'd0,   8'd0,   8'd0);   // bin 0 outgrows the peak, which stays
      push_req(OP_READ,       8'd0,   8'd0,   8'd0,   8'd0);
      push_req(OP_READ,       8'hA5,  8'h5A,  8'hC3,  8'd255);
      push_req(OP_READ,       8'd0,   8'd0,   8'd0,   8'd1);
      push_req(OP_READ,       8'd0,   8'd0,   8'd0,   8'd128);
      push_req(OP_READ_ALIAS, 8'd0,   8'd0,   8'd0,   8'd255);
      push_req(OP_READ_ALIAS, 8'hFF,  8'hFF,  8'hFF,  8'd2);
      push_req(OP_CLEAR,      8'hFF,  8'hFF,  8'hFF,  8'hFF);
      push_req(OP_READ,       8'd0,   8'd0,   8'd0,   8'd255);
      push_req(OP_READ,       8'd0,   8'd0,   8'd0,   8'd0);
      push_req(OP_ADD,        8'hAA,  8'h55,  8'hAA,  8'h55);
      push_req(OP_ADD,        8'h55,  8'hAA,  8'h55,  8'hAA);
      push_req(OP_ADD,        8'hAA,  8'hAA,  8'h55,  8'h00);
      push_req(OP_READ,       8'd0,   8'd0,   8'd0,   8'hAA);
      push_req(OP_READ,       8'd0,   8'd0,   8'd0,   8'h55);
      push_req(OP_CLEAR,      8'd0,   8'd0,   8'd0,   8'd0);
      wait_drained();

      // Random phases: receiver-heavy idling, sender-heavy idling, then none.
      // Each phase drains fully before the next one starts.
      for (int phase = 0; phase < 3; phase++) begin
         send_gap_pct = (phase == 0) ? 25 : (phase == 1) ? 69 : 0;
         rsp_hold_pct = (phase == 0) ? 69 : (phase == 1) ? 25 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(99);
            if (pick < 1)
               op = OP_CLEAR;
            else if (pick < 61)
               op = OP_ADD;
            else if (pick < 92)
               op = OP_READ;
            else
               op = OP_READ_ALIAS;
            push_req(op, pick_code(), pick_code(), pick_code(), pick_code());
         end
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("rgb_histogram_engine_unit test passed");
      else
         $display("rgb_histogram_engine_unit test failed");
      $finish;
   end

endmodule
